### rtl/length_prefixed_message_ring_unit_macros.svh
// Assertion macros used by the ring unit datapath module.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LPMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LPMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPMR_ASSERT(lbl, prop, msg)
`define LPMR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/lpmr_pkg.sv
package lpmr_pkg;

    localparam int unsigned RING_BYTES = 1024;
    localparam int unsigned MAX_MSG    = 64;
    localparam int unsigned HDR_BYTES  = 4;
    localparam int unsigned PTR_W      = $clog2(RING_BYTES);
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CMP_W      = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - BYTE_W - LEN_W;

    localparam logic [PTR_W-1:0] PTR_ONE     = PTR_W'(1);
    localparam logic [PTR_W-1:0] HDR_PTR_OFS = PTR_W'(HDR_BYTES);

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_READ   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_WDATA,
        S_RHDR,
        S_RDATA
    } t_state;

    typedef struct packed {
        logic load;
        logic wr_hdr;
        logic wr_reject;
        logic wr_data;
        logic rd_hdr;
        logic rd_empty;
        logic rd_first;
        logic rd_byte;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic admit;
        logic open;
        logic used_zero;
        logic hdr_zero;
        logic last_byte;
        logic slot;
    } t_stat;

endpackage

### rtl/length_prefixed_message_ring_unit.sv
// Byte ring of 1024 entries holding messages of 1 to 64 bytes, each stored behind a
// length header. A write word gets its status word when its byte is written, a
// rejected write straight from decode; the controller handles one word at a time.
// A read word fetches the header, then its first byte, then streams one byte per cycle
// while the output is taken, paced by the single registered read port of the ring
// memory. Ring contents are undefined after reset and need no clearing pass.
module length_prefixed_message_ring_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [6:0] msg_len, [14:7] data_in, [15] zero
    input  logic [lpmr_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] req_type, [1] start_of_msg
    input  logic [lpmr_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] data_out, [14:8] read_len, [15] zero
    output logic [lpmr_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [lpmr_pkg::OUT_USER_W-1:0]      m_tuser,
    output logic                                 m_tlast
);

    lpmr_pkg::t_cmd  w_cmd;
    lpmr_pkg::t_stat w_stat;

    lpmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpmr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

### rtl/lpmr_ctrl.sv
module lpmr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  lpmr_pkg::t_stat i_stat,
    output lpmr_pkg::t_cmd  o_cmd
);

    lpmr_pkg::t_state r_state;
    lpmr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpmr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            lpmr_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lpmr_pkg::S_DEC;
                end
            end
            lpmr_pkg::S_DEC: begin
                if (i_stat.is_read) begin
                    if (i_stat.used_zero) begin
                        if (i_stat.slot) begin
                            o_cmd.rd_empty = 1'b1;
                            n_state        = lpmr_pkg::S_IDLE;
                        end
                    end else begin
                        o_cmd.rd_hdr = 1'b1;
                        n_state      = lpmr_pkg::S_RHDR;
                    end
                end else if (i_stat.admit) begin
                    o_cmd.wr_hdr = 1'b1;
                    n_state      = lpmr_pkg::S_WDATA;
                end else if (i_stat.open) begin
                    n_state = lpmr_pkg::S_WDATA;
                end else if (i_stat.slot) begin
                    o_cmd.wr_reject = 1'b1;
                    n_state         = lpmr_pkg::S_IDLE;
                end
            end
            lpmr_pkg::S_WDATA: begin
                if (i_stat.slot) begin
                    o_cmd.wr_data = 1'b1;
                    n_state       = lpmr_pkg::S_IDLE;
                end
            end
            lpmr_pkg::S_RHDR: begin
                if (i_stat.hdr_zero) begin
                    if (i_stat.slot) begin
                        o_cmd.rd_empty = 1'b1;
                        n_state        = lpmr_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = lpmr_pkg::S_RDATA;
                end
            end
            lpmr_pkg::S_RDATA: begin
                if (i_stat.slot) begin
                    o_cmd.rd_byte = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = lpmr_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lpmr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/lpmr_dp.sv
`include "length_prefixed_message_ring_unit_macros.svh"

module lpmr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpmr_pkg::t_cmd                       i_cmd,
    output lpmr_pkg::t_stat                      o_stat,
    input  logic [lpmr_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic [lpmr_pkg::IN_USER_W-1:0]       i_s_tuser,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [lpmr_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [lpmr_pkg::OUT_USER_W-1:0]      o_m_tuser,
    output logic                                 o_m_tlast
);

    logic [lpmr_pkg::BYTE_W-1:0] r_ring [lpmr_pkg::RING_BYTES];
    logic [lpmr_pkg::BYTE_W-1:0] r_rdata;

    logic                        r_req;
    logic                        r_start;
    logic [lpmr_pkg::LEN_W-1:0]  r_len;
    logic [lpmr_pkg::BYTE_W-1:0] r_din;

    logic [lpmr_pkg::PTR_W-1:0]  r_head,      n_head;
    logic [lpmr_pkg::PTR_W-1:0]  r_tail,      n_tail;
    logic [lpmr_pkg::PTR_W-1:0]  r_cursor,    n_cursor;
    logic [lpmr_pkg::LEN_W-1:0]  r_remaining, n_remaining;
    logic                        r_dropping,  n_dropping;
    logic [lpmr_pkg::PTR_W-1:0]  r_pos,       n_pos;
    logic [lpmr_pkg::LEN_W-1:0]  r_cnt,       n_cnt;
    logic [lpmr_pkg::LEN_W-1:0]  r_rlen;
    logic                        r_ovalid,    n_ovalid;

    lpmr_pkg::t_status           r_ostat;
    logic [lpmr_pkg::BYTE_W-1:0] r_odata;
    logic [lpmr_pkg::LEN_W-1:0]  r_olen;
    logic                        r_olast;

    logic [lpmr_pkg::PTR_W-1:0]  w_free;
    logic [lpmr_pkg::PTR_W-1:0]  w_used;
    logic [lpmr_pkg::CMP_W-1:0]  w_need;
    logic                        w_len_ok;
    logic [lpmr_pkg::LEN_W-1:0]  w_n;
    logic                        w_last_byte;
    logic                        w_slot;
    logic                        w_emit;
    logic                        w_wr_en;
    logic [lpmr_pkg::PTR_W-1:0]  w_wr_addr;
    logic [lpmr_pkg::BYTE_W-1:0] w_wr_byte;
    logic                        w_rd_en;
    logic                        w_rd_next;
    logic [lpmr_pkg::PTR_W-1:0]  w_rd_addr;

    // The ring keeps one byte in reserve, so free space is head minus tail.
    assign w_free      = r_head - r_tail;
    assign w_used      = r_tail - lpmr_pkg::PTR_ONE - r_head;
    assign w_need      = lpmr_pkg::CMP_W'(r_len) + lpmr_pkg::CMP_W'(lpmr_pkg::HDR_BYTES);
    assign w_len_ok    = (r_len != '0) && (r_len <= lpmr_pkg::LEN_W'(lpmr_pkg::MAX_MSG));
    assign w_n         = (r_rdata > lpmr_pkg::BYTE_W'(lpmr_pkg::MAX_MSG)) ?
                         lpmr_pkg::LEN_W'(lpmr_pkg::MAX_MSG) : lpmr_pkg::LEN_W'(r_rdata);
    assign w_last_byte = (r_cnt == lpmr_pkg::LEN_W'(1));
    assign w_slot      = !r_ovalid || i_m_tready;
    assign w_emit      = i_cmd.wr_reject | i_cmd.wr_data | i_cmd.rd_empty | i_cmd.rd_byte;

    assign o_stat.is_read   = r_req;
    assign o_stat.admit     = r_start && w_len_ok && (w_need <= lpmr_pkg::CMP_W'(w_free));
    assign o_stat.open      = !r_start && !r_dropping && (r_remaining != '0);
    assign o_stat.used_zero = (w_used == '0);
    assign o_stat.hdr_zero  = (r_rdata == '0);
    assign o_stat.last_byte = w_last_byte;
    assign o_stat.slot      = w_slot;

    // Only the low header byte is stored; the upper three are left unwritten and never read.
    assign w_wr_en   = i_cmd.wr_hdr | i_cmd.wr_data;
    assign w_wr_addr = i_cmd.wr_hdr ? (r_tail - lpmr_pkg::PTR_ONE) : r_cursor;
    assign w_wr_byte = i_cmd.wr_hdr ? lpmr_pkg::BYTE_W'(r_len) : r_din;
    assign w_rd_next = i_cmd.rd_first | (i_cmd.rd_byte & !w_last_byte);
    assign w_rd_en   = i_cmd.rd_hdr | w_rd_next;
    assign w_rd_addr = i_cmd.rd_hdr ? r_head : r_pos;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cursor    = r_cursor;
        n_remaining = r_remaining;
        n_dropping  = r_dropping;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_ovalid    = r_ovalid;
        if (i_cmd.wr_hdr) begin
            n_cursor    = r_tail + lpmr_pkg::HDR_PTR_OFS - lpmr_pkg::PTR_ONE;
            n_remaining = r_len;
            n_dropping  = 1'b0;
        end
        if (i_cmd.wr_reject) begin
            if (r_start) begin
                n_remaining = (r_len != '0) ? (r_len - lpmr_pkg::LEN_W'(1)) : '0;
                n_dropping  = (r_len > lpmr_pkg::LEN_W'(1));
            end else if (r_dropping) begin
                n_remaining = (r_remaining != '0) ? (r_remaining - lpmr_pkg::LEN_W'(1)) : '0;
                n_dropping  = (r_remaining > lpmr_pkg::LEN_W'(1));
            end
        end
        if (i_cmd.wr_data) begin
            n_cursor    = r_cursor + lpmr_pkg::PTR_ONE;
            n_remaining = r_remaining - lpmr_pkg::LEN_W'(1);
            if (r_remaining == lpmr_pkg::LEN_W'(1)) begin
                n_tail = r_cursor + lpmr_pkg::PTR_W'(2);
            end
        end
        if (i_cmd.rd_hdr) begin
            n_pos = r_head + lpmr_pkg::HDR_PTR_OFS;
        end
        if (w_rd_next) begin
            n_pos = r_pos + lpmr_pkg::PTR_ONE;
        end
        if (i_cmd.rd_first) begin
            n_cnt = w_n;
        end
        if (i_cmd.rd_byte) begin
            n_cnt = r_cnt - lpmr_pkg::LEN_W'(1);
            if (w_last_byte) begin
                n_head = r_pos;
            end
        end
        if (w_emit) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= lpmr_pkg::PTR_ONE;
            r_cursor    <= '0;
            r_remaining <= '0;
            r_dropping  <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cursor    <= n_cursor;
            r_remaining <= n_remaining;
            r_dropping  <= n_dropping;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[w_wr_addr] <= w_wr_byte;
        end
        if (w_rd_en) begin
            r_rdata <= r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_s_tuser[0];
            r_start <= i_s_tuser[1];
            r_len   <= i_s_tdata[lpmr_pkg::LEN_W-1:0];
            r_din   <= i_s_tdata[lpmr_pkg::LEN_W +: lpmr_pkg::BYTE_W];
        end
        if (i_cmd.rd_first) begin
            r_rlen <= w_n;
        end
        if (w_emit) begin
            if (i_cmd.rd_byte) begin
                r_ostat <= lpmr_pkg::STAT_READ;
            end else if (i_cmd.rd_empty) begin
                r_ostat <= lpmr_pkg::STAT_EMPTY;
            end else if (i_cmd.wr_data) begin
                r_ostat <= lpmr_pkg::STAT_ACCEPT;
            end else begin
                r_ostat <= lpmr_pkg::STAT_REJECT;
            end
            r_odata <= i_cmd.rd_byte ? r_rdata : '0;
            r_olen  <= i_cmd.rd_byte ? r_rlen : '0;
            r_olast <= i_cmd.rd_byte ? w_last_byte : 1'b1;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{lpmr_pkg::OUT_PAD_W{1'b0}}, r_olen, r_odata};
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    `LPMR_ASSERT(a_drop_has_rem, r_dropping |-> (r_remaining != '0), "Dropping with no bytes due.")
    `LPMR_ASSERT(a_emit_slot, w_emit |-> (!r_ovalid || i_m_tready), "Result overwrote a held word.")
    `LPMR_ASSERT(a_wdata_open, i_cmd.wr_data |-> ((r_remaining != '0) && !r_dropping), "Data write without an open message.")
    `LPMR_ASSERT_NEXT(a_rd_cnt, i_cmd.rd_first, r_cnt != '0, "Read started with zero length.")

endmodule

### bench/tb_length_prefixed_message_ring_unit.sv
`timescale 1ns / 100ps

module tb_length_prefixed_message_ring_unit;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned RANDOM_WORDS = 260;
    localparam int unsigned TAIL_CYCLES  = 20;

    typedef struct packed {
        lpmr_pkg::t_status           status;
        logic [lpmr_pkg::BYTE_W-1:0] data;
        logic [lpmr_pkg::LEN_W-1:0]  len;
        logic                        last;
    } t_result;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [6:0] msg_len, [14:7] data_in, [15] zero
    logic [lpmr_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    // [0] req_type, [1] start_of_msg
    logic [lpmr_pkg::IN_USER_W-1:0]  s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [7:0] data_out, [14:8] read_len, [15] zero
    logic [lpmr_pkg::OUT_DATA_W-1:0] m_tdata;
    // [1:0] status
    logic [lpmr_pkg::OUT_USER_W-1:0] m_tuser;
    logic                            m_tlast;

    logic [lpmr_pkg::BYTE_W-1:0] ring_mem [lpmr_pkg::RING_BYTES];
    logic [lpmr_pkg::PTR_W-1:0]  head_pos;
    logic [lpmr_pkg::PTR_W-1:0]  tail_pos;
    logic [lpmr_pkg::PTR_W-1:0]  wr_pos;
    logic [lpmr_pkg::LEN_W-1:0]  wr_left;
    logic                        wr_drop;

    t_result     pending_results [$];
    t_result     due_word;
    int unsigned error_cnt  = 0;
    int unsigned word_cnt   = 0;
    int unsigned result_cnt = 0;
    int unsigned reject_cnt = 0;
    int unsigned empty_cnt  = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned stall_left = 0;
    int unsigned max_gap    = 8;
    int unsigned max_stall  = 8;

    length_prefixed_message_ring_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [lpmr_pkg::PTR_W-1:0] ring_free();
        return head_pos - tail_pos;
    endfunction

    function automatic logic [lpmr_pkg::PTR_W-1:0] ring_used();
        return tail_pos - lpmr_pkg::PTR_ONE - head_pos;
    endfunction

    function automatic void push_result(input lpmr_pkg::t_status st,
                                        input logic [lpmr_pkg::BYTE_W-1:0] d,
                                        input logic [lpmr_pkg::LEN_W-1:0] l,
                                        input logic lst);
        t_result word;
        word.status = st;
        word.data   = d;
        word.len    = l;
        word.last   = lst;
        pending_results.push_back(word);
        if (st == lpmr_pkg::STAT_REJECT) begin
            reject_cnt++;
        end
        if (st == lpmr_pkg::STAT_EMPTY) begin
            empty_cnt++;
        end
    endfunction

    function automatic void predict_write(input logic som,
                                          input logic [lpmr_pkg::LEN_W-1:0] len,
                                          input logic [lpmr_pkg::BYTE_W-1:0] b);
        int unsigned room;
        int unsigned k;
        room = ring_free();
        if (som) begin
            wr_left = '0;
            wr_drop = 1'b0;
            if (len == 0 || len > lpmr_pkg::MAX_MSG || len + lpmr_pkg::HDR_BYTES > room) begin
                wr_left = (len > 0) ? len - 1'b1 : '0;
                wr_drop = (wr_left != 0);
                push_result(lpmr_pkg::STAT_REJECT, '0, '0, 1'b1);
                return;
            end
            // The header goes at the current write position, little-endian.
            wr_pos = tail_pos - lpmr_pkg::PTR_ONE;
            for (k = 0; k < lpmr_pkg::HDR_BYTES; k++) begin
                ring_mem[wr_pos] = (k == 0) ? {1'b0, len} : '0;
                wr_pos = wr_pos + lpmr_pkg::PTR_ONE;
            end
            wr_left = len;
        end else if (wr_drop) begin
            if (wr_left != 0) begin
                wr_left = wr_left - 1'b1;
            end
            if (wr_left == 0) begin
                wr_drop = 1'b0;
            end
            push_result(lpmr_pkg::STAT_REJECT, '0, '0, 1'b1);
            return;
        end else if (wr_left == 0) begin
            push_result(lpmr_pkg::STAT_REJECT, '0, '0, 1'b1);
            return;
        end
        ring_mem[wr_pos] = b;
        wr_pos  = wr_pos + lpmr_pkg::PTR_ONE;
        wr_left = wr_left - 1'b1;
        if (wr_left == 0) begin
            tail_pos = wr_pos + lpmr_pkg::PTR_ONE;
        end
        push_result(lpmr_pkg::STAT_ACCEPT, '0, '0, 1'b1);
    endfunction

    function automatic void predict_read();
        logic [lpmr_pkg::PTR_W-1:0] pos;
        logic [31:0]                hdr;
        int unsigned                cnt;
        int unsigned                k;
        if (ring_used() == 0) begin
            push_result(lpmr_pkg::STAT_EMPTY, '0, '0, 1'b1);
            return;
        end
        pos = head_pos;
        hdr = '0;
        for (k = 0; k < lpmr_pkg::HDR_BYTES; k++) begin
            hdr = hdr | (32'(ring_mem[pos]) << (8 * k));
            pos = pos + lpmr_pkg::PTR_ONE;
        end
        cnt = (hdr > lpmr_pkg::MAX_MSG) ? lpmr_pkg::MAX_MSG : hdr;
        if (cnt == 0) begin
            push_result(lpmr_pkg::STAT_EMPTY, '0, '0, 1'b1);
            return;
        end
        for (k = 0; k < cnt; k++) begin
            push_result(lpmr_pkg::STAT_READ, ring_mem[pos], lpmr_pkg::LEN_W'(cnt),
                        (k + 1 == cnt));
            pos = pos + lpmr_pkg::PTR_ONE;
        end
        head_pos = pos;
    endfunction

    task automatic send_word(input logic rd, input logic som,
                             input logic [lpmr_pkg::LEN_W-1:0] len,
                             input logic [lpmr_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(max_gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, b, len};
        s_tuser  <= {som, rd};
        do @(posedge i_clk); while (!s_tready);
        word_cnt++;
        if (rd) begin
            predict_read();
        end else begin
            predict_write(som, len, b);
        end
    endtask

    task automatic send_read();
        send_word(1'b1, 1'($urandom), lpmr_pkg::LEN_W'($urandom), lpmr_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_byte();
        send_word(1'b0, 1'b0, lpmr_pkg::LEN_W'($urandom), lpmr_pkg::BYTE_W'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            error_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            result_cnt++;
            stall_left = $urandom_range(max_stall);
            if (pending_results.size() == 0) begin
                error_cnt++;
                $display("%0t: unexpected word, expected none, got status %0h data %0h len %0h last %0b",
                         $time, m_tuser, m_tdata[7:0], m_tdata[14:8], m_tlast);
            end else begin
                due_word = pending_results.pop_front();
                check_field("status", due_word.status, m_tuser);
                check_field("data_out", due_word.data, m_tdata[7:0]);
                check_field("read_len", due_word.len, m_tdata[14:8]);
                check_field("last", due_word.last, m_tlast);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words outstanding.",
                     cycle_cnt, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_basic_transfer();
        max_gap   = 8;
        max_stall = 8;
        send_word(1'b1, 1'b0, '0, '0);
        send_word(1'b0, 1'b1, 7'd1, 8'hFF);
        send_word(1'b1, 1'b1, 7'h7F, 8'h00);
        send_word(1'b1, 1'b0, '0, '0);
    endtask

    task automatic test_special_cases();
        send_word(1'b0, 1'b1, 7'd0, 8'h00);
        send_word(1'b0, 1'b0, 7'h55, 8'hAA);
        send_word(1'b0, 1'b1, 7'h7F, 8'h12);
        send_byte();
        send_byte();
        send_word(1'b0, 1'b1, 7'(lpmr_pkg::MAX_MSG + 1), 8'h34);
        send_word(1'b0, 1'b1, 7'd5, 8'hA5);
        send_word(1'b0, 1'b0, 7'd0, 8'h5A);
        send_word(1'b0, 1'b1, 7'd3, 8'h01);
        send_word(1'b0, 1'b0, 7'd0, 8'h02);
        send_read();
        send_word(1'b0, 1'b0, 7'd0, 8'h03);
        send_word(1'b0, 1'b1, 7'd2, 8'h04);
        send_read();
        send_word(1'b0, 1'b0, 7'd0, 8'h05);
        send_read();
    endtask

    task automatic test_max_length();
        int unsigned k;
        send_word(1'b0, 1'b1, 7'(lpmr_pkg::MAX_MSG), 8'h00);
        for (k = 1; k < lpmr_pkg::MAX_MSG; k++) begin
            send_word(1'b0, 1'b0, lpmr_pkg::LEN_W'($urandom),
                      (k == lpmr_pkg::MAX_MSG - 1) ? 8'hFF : lpmr_pkg::BYTE_W'($urandom));
        end
        send_read();
    endtask

    task automatic test_fill_and_drain();
        int unsigned fit_len;
        int unsigned k;
        while (ring_used() != 0) send_read();
        while (ring_free() > 12) send_word(1'b0, 1'b1, 7'd1, lpmr_pkg::BYTE_W'($urandom));
        // This message takes exactly the remaining free space.
        fit_len = ring_free() - lpmr_pkg::HDR_BYTES;
        send_word(1'b0, 1'b1, lpmr_pkg::LEN_W'(fit_len), lpmr_pkg::BYTE_W'($urandom));
        for (k = 1; k < fit_len; k++) begin
            send_byte();
        end
        send_word(1'b0, 1'b1, 7'd1, lpmr_pkg::BYTE_W'($urandom));
        send_word(1'b0, 1'b1, 7'd4, lpmr_pkg::BYTE_W'($urandom));
        repeat (3) send_byte();
        send_byte();
        wait_drained();
        while (ring_used() != 0) send_read();
        send_read();
    endtask

    task automatic test_random_traffic();
        int unsigned first_word;
        int unsigned mode_mark;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        first_word = word_cnt;
        mode_mark  = word_cnt;
        while (word_cnt - first_word < RANDOM_WORDS) begin
            if (word_cnt - mode_mark >= 40) begin
                mode_mark = word_cnt;
                pick      = $urandom_range(3);
                max_gap   = pick[0] ? 8 : 0;
                max_stall = pick[1] ? 8 : 0;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = ($urandom_range(5) == 0) ? $urandom_range(lpmr_pkg::MAX_MSG, 13) :
                      $urandom_range(12, 1);
                send_word(1'b0, 1'b1, lpmr_pkg::LEN_W'(len), lpmr_pkg::BYTE_W'($urandom));
                for (k = 1; k < len; k++) begin
                    send_byte();
                end
            end else if (pick < 85) begin
                send_read();
            end else if (pick < 92) begin
                len = $urandom_range(lpmr_pkg::MAX_MSG, 2);
                send_word(1'b0, 1'b1, lpmr_pkg::LEN_W'(len), lpmr_pkg::BYTE_W'($urandom));
                repeat ($urandom_range(len - 2)) send_byte();
            end else if (pick < 97) begin
                len = $urandom_range(1) ? 0 : $urandom_range(127, lpmr_pkg::MAX_MSG + 1);
                send_word(1'b0, 1'b1, lpmr_pkg::LEN_W'(len), lpmr_pkg::BYTE_W'($urandom));
                repeat ($urandom_range(3)) send_byte();
            end else begin
                send_byte();
            end
        end
        max_gap   = 8;
        max_stall = 8;
    endtask

    initial begin
        int unsigned k;
        for (k = 0; k < lpmr_pkg::RING_BYTES; k++) begin
            ring_mem[k] = '0;
        end
        head_pos = '0;
        tail_pos = lpmr_pkg::PTR_ONE;
        wr_pos   = '0;
        wr_left  = '0;
        wr_drop  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_transfer();
        test_special_cases();
        test_max_length();
        test_fill_and_drain();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d words and checked %0d result words, including a full ring and wrap.",
                 word_cnt, result_cnt);
        $display("Saw %0d rejected writes and %0d reads of an empty ring, %0d mismatches.",
                 reject_cnt, empty_cnt, error_cnt);
        if (error_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
